FILE: rtl/aessb_pkg.sv
package aessb_pkg;

   localparam int unsigned BYTE_W = 8;

   typedef logic [BYTE_W-1:0] byte_type;

   // affine constant folded into the bottom layer (bits 6, 5, 1, 0 of the byte)
   localparam byte_type SBOX_AFFINE = 8'h63;

endpackage

FILE: rtl/aessb_core.sv
module aessb_core (
   input  aessb_pkg::byte_type in_byte,
   output aessb_pkg::byte_type sub_byte
);
   import aessb_pkg::*;

   // u/z/g are msb-first: u[i] is byte bit 7-i
   logic [7:0]  u;
   logic [21:0] g;
   logic [7:0]  z;
   logic        p, q, r, w, k;
   logic        e41, e42, e43, e44, e45;
   byte_type    zb;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         u[i] = in_byte[7-i];
      end

      // linear top layer
      g[0]  = u[7];
      g[1]  = u[1] ^ u[2] ^ u[7];
      g[2]  = u[0] ^ u[1] ^ u[2] ^ u[7];
      g[3]  = u[0] ^ u[1] ^ u[2] ^ u[5] ^ u[6] ^ u[7];
      g[4]  = u[1] ^ u[2] ^ u[3] ^ u[7];
      g[5]  = u[1] ^ u[2] ^ u[6] ^ u[7];
      g[6]  = u[0] ^ u[3] ^ u[4] ^ u[6] ^ u[7];
      g[7]  = u[1] ^ u[4] ^ u[5] ^ u[6] ^ u[7];
      g[8]  = u[0] ^ u[5];
      g[9]  = u[0] ^ u[3];
      g[10] = u[0] ^ u[1] ^ u[2] ^ u[3] ^ u[4] ^ u[6];
      g[11] = u[1] ^ u[4] ^ u[5] ^ u[6];
      g[12] = u[0] ^ u[3] ^ u[5] ^ u[6];
      g[13] = u[0] ^ u[6];
      g[14] = u[3] ^ u[5];
      g[15] = u[0] ^ u[3] ^ u[4] ^ u[6];
      g[16] = u[2] ^ u[4] ^ u[6] ^ u[5];
      g[17] = u[0] ^ u[2] ^ u[3] ^ u[5];
      g[18] = u[0] ^ u[2] ^ u[4] ^ u[5] ^ u[6];
      g[19] = u[1] ^ u[2] ^ u[3] ^ u[4] ^ u[5] ^ u[6];
      g[20] = u[0] ^ u[1] ^ u[3] ^ u[4] ^ u[5] ^ u[6];
      g[21] = u[0] ^ u[2] ^ u[4] ^ u[5];

      // middle bits
      p = g[12] & g[15];
      q = p;
      p = p ^ (g[3] & g[6]);
      q = q ^ (g[4] & g[0]);
      q = q ^ (g[8] & g[10]);
      r = g[14] & g[17];
      p = p ^ r;
      r = r ^ (g[5] & g[1]);
      r = r ^ (g[13] & g[16]);
      w = (g[2] & g[7]) ^ (g[13] & g[16]) ^ (g[8] & g[10]);
      k = g[9] & g[11];
      p = p ^ k ^ g[20];
      q = q ^ k ^ g[19];
      r = r ^ k ^ g[21];
      w = w ^ k ^ g[18];

      // 4-bit nonlinear core
      r = r ^ (q & w);
      w = w ^ r;
      q = q ^ (p & w);
      w = w ^ (q & r);
      r = r ^ w;
      q = q ^ p;
      p = p ^ (q & w);
      w = w ^ (r & q & p);
      p = p ^ q;

      // bottom layer
      e41 = q ^ w;
      e42 = p ^ r;
      e43 = p ^ q;
      e44 = r ^ w;
      e45 = e42 ^ e41;

      z[6] = e44 & g[15];
      z[1] = w & g[6];
      z[0] = e43 & g[16];
      z[4] = q & g[1];
      z[3] = e44 & g[12];
      z[5] = w & g[3];
      z[2] = e43 & g[13];
      z[7] = q & g[5];
      z[0] = z[0] ^ z[4];
      z[6] = z[6] ^ z[0];
      z[2] = z[2] ^ (e42 & g[9]);
      z[0] = z[0] ^ (e42 & g[11]);
      z[5] = z[5] ^ (e45 & g[14]);
      z[0] = z[0] ^ (e45 & g[17]);
      z[7] = z[7] ^ z[2];
      z[1] = z[1] ^ z[6];
      z[2] = z[2] ^ (p & g[2]);
      z[3] = z[3] ^ z[5];
      z[6] = z[6] ^ (r & g[0]);
      z[4] = z[4] ^ z[6];
      z[4] = z[4] ^ (p & g[7]);
      z[5] = z[5] ^ (r & g[4]);
      z[3] = z[3] ^ (e42 & g[9]);
      z[6] = z[6] ^ (e45 & g[17]);
      z[6] = z[6] ^ (e41 & g[10]);
      z[7] = z[7] ^ (e45 & g[14]);
      z[2] = z[2] ^ z[6];
      z[5] = z[5] ^ z[2];
      z[2] = z[2] ^ z[0];
      z[0] = z[0] ^ z[3];
      z[3] = z[3] ^ z[1];
      z[7] = z[7] ^ z[4];
      z[2] = z[2] ^ (e41 & g[8]);
      z[6] = z[6] ^ z[7];
      z[4] = z[4] ^ z[3];
      z[1] = z[1] ^ z[0];

      for (int i = 0; i < 8; i++) begin
         zb[7-i] = z[i];
      end
   end

   assign sub_byte = zb ^ SBOX_AFFINE;

endmodule

FILE: rtl/aes_sbox_logic_circuit_top.sv
// aes forward s-box built from gates, one byte per word on each channel
//
// request channel: req_valid, req_in_byte, req_stall (driven here)
// response channel: rsp_valid, rsp_sub_byte, rsp_stall (driven by the sink)
// a word moves on a rising edge where valid is high and stall is low
//
// two register stages: the request word lands in an input register, the
// gate network sits between it and the output register
// the substitute is offered on rsp from the output register
// throughput: one word per cycle while the sink does not stall
//
// when the sink stalls, the output register holds its word and the input
// register still takes one more word; req_stall rises only when both
// stages are full and the sink is stalling
// synchronous reset clears both valid flags; the byte registers are not reset
module aes_sbox_logic_circuit_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aessb_pkg::byte_type  req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aessb_pkg::byte_type  rsp_sub_byte
);
   import aessb_pkg::*;

   // input stage
   logic     in_vld_ff, in_vld_in;
   byte_type in_byte_ff, in_byte_in;
   // output stage
   logic     out_vld_ff, out_vld_in;
   byte_type out_byte_ff, out_byte_in;

   logic     out_adv;    // output register can take a new word
   logic     in_free;    // input register can take a new word
   byte_type sub_byte;

   aessb_core u_core (
      .in_byte  (in_byte_ff),
      .sub_byte (sub_byte)
   );

   // handshake: output frees when empty or drained this cycle
   always_comb begin
      out_adv   = !out_vld_ff || !rsp_stall;
      in_free   = !in_vld_ff || out_adv;
      req_stall = !in_free;

      in_vld_in  = in_free ? req_valid : in_vld_ff;
      in_byte_in = (in_free && req_valid) ? req_in_byte : in_byte_ff;

      out_vld_in  = out_adv ? in_vld_ff : out_vld_ff;
      out_byte_in = (out_adv && in_vld_ff) ? sub_byte : out_byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_byte_ff <= out_byte_in;
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_sub_byte = out_byte_ff;

endmodule

FILE: tb/tb_aes_sbox_logic_circuit_top.sv
module tb_aes_sbox_logic_circuit_top;
   import aessb_pkg::*;

   // one expected response word, tagged with the request byte for reporting
   typedef struct packed {
      byte_type in_byte;
      byte_type sub_byte;
   } sbox_case_type;

   // directed row: when typed is set, sub_byte is the hand-entered answer,
   // otherwise the gate-level predictor supplies it
   typedef struct packed {
      byte_type in_byte;
      logic     typed;
      byte_type sub_byte;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam int RANDOM_WORDS  = 280;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int MAX_PRINTS    = 40;

   // all-zero byte: every product in the network is zero, only the affine
   // constant survives; the rest covers the extremes, walking ones/zeros and alternating patterns
   localparam stim_row_type STIM_ROWS [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, SBOX_AFFINE},
      '{8'hff, 1'b0, 8'h00},
      '{8'h01, 1'b0, 8'h00},
      '{8'h02, 1'b0, 8'h00},
      '{8'h04, 1'b0, 8'h00},
      '{8'h08, 1'b0, 8'h00},
      '{8'h10, 1'b0, 8'h00},
      '{8'h20, 1'b0, 8'h00},
      '{8'h40, 1'b0, 8'h00},
      '{8'h80, 1'b0, 8'h00},
      '{8'hfe, 1'b0, 8'h00},
      '{8'hfd, 1'b0, 8'h00},
      '{8'hfb, 1'b0, 8'h00},
      '{8'hf7, 1'b0, 8'h00},
      '{8'hef, 1'b0, 8'h00},
      '{8'hdf, 1'b0, 8'h00},
      '{8'hbf, 1'b0, 8'h00},
      '{8'h7f, 1'b0, 8'h00},
      '{8'h55, 1'b0, 8'h00},
      '{8'haa, 1'b0, 8'h00},
      '{8'h0f, 1'b0, 8'h00},
      '{8'hf0, 1'b0, 8'h00}
   };

   // clock, reset and every block input start at a known value
   logic     clock       = 1'b0;
   logic     reset       = 1'b1;
   logic     req_valid   = 1'b0;
   byte_type req_in_byte = '0;
   logic     rsp_stall   = 1'b0;
   logic     req_stall;
   logic     rsp_valid;
   byte_type rsp_sub_byte;

   // expected substitutes in request order
   sbox_case_type sub_expect_q [$];
   sbox_case_type rsp_head;

   int  err_cnt     = 0;
   int  sent_cnt    = 0;
   int  checked_cnt = 0;
   int  stall_cnt   = 0;
   int  burst_left  = 0;
   int  sink_cycle  = 0;
   bit  byte_seen [256];

   aes_sbox_logic_circuit_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sub_byte (rsp_sub_byte)
   );

   always #4 clock = ~clock;

   // gate-level forward s-box, msb-first bit numbering inside:
   // xb[0] is byte bit 7, the result o[0] lands on bit 7 as well
   function automatic byte_type sbox_forward(input byte_type x);
      logic [0:7]  xb;
      logic [0:21] t;
      logic [0:7]  o;
      logic        m0, m1, m2, m3, k;
      logic        qw, pr, pq, rw, all4;
      xb = x;

      // linear top layer
      t[0]  = xb[7];
      t[1]  = xb[1] ^ xb[2] ^ xb[7];
      t[2]  = xb[0] ^ xb[1] ^ xb[2] ^ xb[7];
      t[3]  = xb[0] ^ xb[1] ^ xb[2] ^ xb[5] ^ xb[6] ^ xb[7];
      t[4]  = xb[1] ^ xb[2] ^ xb[3] ^ xb[7];
      t[5]  = xb[1] ^ xb[2] ^ xb[6] ^ xb[7];
      t[6]  = xb[0] ^ xb[3] ^ xb[4] ^ xb[6] ^ xb[7];
      t[7]  = xb[1] ^ xb[4] ^ xb[5] ^ xb[6] ^ xb[7];
      t[8]  = xb[0] ^ xb[5];
      t[9]  = xb[0] ^ xb[3];
      t[10] = xb[0] ^ xb[1] ^ xb[2] ^ xb[3] ^ xb[4] ^ xb[6];
      t[11] = xb[1] ^ xb[4] ^ xb[5] ^ xb[6];
      t[12] = xb[0] ^ xb[3] ^ xb[5] ^ xb[6];
      t[13] = xb[0] ^ xb[6];
      t[14] = xb[3] ^ xb[5];
      t[15] = xb[0] ^ xb[3] ^ xb[4] ^ xb[6];
      t[16] = xb[2] ^ xb[4] ^ xb[6] ^ xb[5];
      t[17] = xb[0] ^ xb[2] ^ xb[3] ^ xb[5];
      t[18] = xb[0] ^ xb[2] ^ xb[4] ^ xb[5] ^ xb[6];
      t[19] = xb[1] ^ xb[2] ^ xb[3] ^ xb[4] ^ xb[5] ^ xb[6];
      t[20] = xb[0] ^ xb[1] ^ xb[3] ^ xb[4] ^ xb[5] ^ xb[6];
      t[21] = xb[0] ^ xb[2] ^ xb[4] ^ xb[5];

      // middle bits
      m0 = t[12] & t[15];
      m1 = m0;
      m0 ^= t[3] & t[6];
      m1 ^= t[4] & t[0];
      m1 ^= t[8] & t[10];
      m2 = t[14] & t[17];
      m0 ^= m2;
      m2 ^= t[5] & t[1];
      m2 ^= t[13] & t[16];
      m3 = (t[2] & t[7]) ^ (t[13] & t[16]) ^ (t[8] & t[10]);
      k  = t[9] & t[11];
      m0 ^= k ^ t[20];
      m1 ^= k ^ t[19];
      m2 ^= k ^ t[21];
      m3 ^= k ^ t[18];

      // 4-bit core
      m2 ^= m1 & m3;
      m3 ^= m2;
      m1 ^= m0 & m3;
      m3 ^= m1 & m2;
      m2 ^= m3;
      m1 ^= m0;
      m0 ^= m1 & m3;
      m3 ^= (m2 & m1) & m0;
      m0 ^= m1;

      // bottom layer
      qw   = m1 ^ m3;
      pr   = m0 ^ m2;
      pq   = m0 ^ m1;
      rw   = m2 ^ m3;
      all4 = pr ^ qw;

      o[6] = rw & t[15];
      o[1] = m3 & t[6];
      o[0] = pq & t[16];
      o[4] = m1 & t[1];
      o[3] = rw & t[12];
      o[5] = m3 & t[3];
      o[2] = pq & t[13];
      o[7] = m1 & t[5];
      o[0] ^= o[4];
      o[6] ^= o[0];
      o[2] ^= pr & t[9];
      o[0] ^= pr & t[11];
      o[5] ^= all4 & t[14];
      o[0] ^= all4 & t[17];
      o[7] ^= o[2];
      o[1] ^= o[6];
      o[2] ^= m0 & t[2];
      o[3] ^= o[5];
      o[6] ^= m2 & t[0];
      o[4] ^= o[6];
      o[4] ^= m0 & t[7];
      o[5] ^= m2 & t[4];
      o[3] ^= pr & t[9];
      o[6] ^= all4 & t[17];
      o[6] ^= qw & t[10];
      o[7] ^= all4 & t[14];
      o[2] ^= o[6];
      o[5] ^= o[2];
      o[2] ^= o[0];
      o[0] ^= o[3];
      o[3] ^= o[1];
      o[7] ^= o[4];
      o[2] ^= qw & t[8];
      o[6] ^= o[7];
      o[4] ^= o[3];
      o[1] ^= o[0];

      return o ^ SBOX_AFFINE;
   endfunction

   task automatic report_mismatch(input string msg);
      err_cnt++;
      if (err_cnt <= MAX_PRINTS)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // offer one request word, hold it through stalls, then maybe open a gap;
   // bursts of random length with gaps of random length, a zero gap
   // merges two bursts so long unbroken stretches also occur
   task automatic send_byte(input byte_type b, input logic typed, input byte_type want);
      sbox_case_type ent;
      int            gap;
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ent.in_byte  = b;
      ent.sub_byte = typed ? want : sbox_forward(b);
      sub_expect_q.push_back(ent);
      sent_cnt++;
      byte_seen[b] = 1'b1;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = $urandom_range(0, 9);
         if (gap != 0) begin
            req_valid   <= 1'b0;
            req_in_byte <= byte_type'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // wait with a bound for every outstanding response word
   task automatic wait_drain;
      int n;
      for (n = 0; n < DRAIN_LIMIT && sub_expect_q.size() != 0; n++)
         @(posedge clock);
   endtask

   // sink stall pattern: the mode, taken from sink_cycle bits 7:6, steps through
   // no stall, light random stall, heavy random stall and alternate cycles
   always @(posedge clock) begin
      sink_cycle <= sink_cycle + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (sink_cycle[7:6])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= sink_cycle[0];
         endcase
         if (rsp_stall) stall_cnt <= stall_cnt + 1;
      end
   end

   // response checker: every word taken by the sink is compared with the
   // oldest expected substitute
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sub_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response word 0x%02h", rsp_sub_byte));
         end else begin
            rsp_head = sub_expect_q.pop_front();
            checked_cnt++;
            if (rsp_sub_byte !== rsp_head.sub_byte)
               report_mismatch($sformatf("in 0x%02h: sub_byte 0x%02h, expected 0x%02h",
                                         rsp_head.in_byte, rsp_sub_byte,
                                         rsp_head.sub_byte));
         end
      end
   end

   // hard stop well past the slowest legal run
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int            i, j;
      int            distinct;
      byte_type      sweep [256];
      byte_type      tmp;
      sbox_case_type left_ent;

      // synchronous reset, held from time zero, then released
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: extremes, walking ones and zeros, alternating patterns
      for (i = 0; i < DIRECTED_ROWS; i++)
         send_byte(STIM_ROWS[i].in_byte, STIM_ROWS[i].typed, STIM_ROWS[i].sub_byte);

      // hold off until the pipeline is empty once
      req_valid <= 1'b0;
      wait_drain();

      // every byte value once, in shuffled order
      for (i = 0; i < 256; i++)
         sweep[i] = byte_type'(i);
      for (i = 255; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = sweep[i];
         sweep[i] = sweep[j];
         sweep[j] = tmp;
      end
      for (i = 0; i < 256; i++)
         send_byte(sweep[i], 1'b0, '0);

      // free random bytes
      for (i = 0; i < RANDOM_WORDS; i++)
         send_byte(byte_type'($urandom), 1'b0, '0);

      // let the last words come out, then report any word still expected
      req_valid <= 1'b0;
      wait_drain();
      repeat (4) @(posedge clock);
      while (sub_expect_q.size() != 0) begin
         left_ent = sub_expect_q.pop_front();
         report_mismatch($sformatf("no response for in 0x%02h", left_ent.in_byte));
      end

      distinct = 0;
      for (i = 0; i < 256; i++)
         if (byte_seen[i]) distinct++;
      $display("substituted %0d request words covering %0d of 256 byte values",
               sent_cnt, distinct);
      $display("%0d responses compared, sink stalled %0d cycles, %0d mismatches",
               checked_cnt, stall_cnt, err_cnt);

      if (err_cnt == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
